>>> src/dfm_pkg.sv
// Shared types and constants for the drag flap mode controller.
// Holds the mode codes, the configuration reset values and the structs passed between modules.
package dfm_pkg;

	typedef enum logic [2:0] {
		MODE_CLOSED = 3'd0,
		MODE_OPEN   = 3'd1,
		MODE_HELD   = 3'd2,
		MODE_TOGGLE = 3'd3,
		MODE_AUTO   = 3'd4
	} mode_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_OPEN_LOCKOUT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LOCKOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_BRAKE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_STEER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_SPEED    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_THROTTLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_BRAKE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_STEER    = 3'd7;

	localparam logic [31:0] RST_OPEN_LOCKOUT  = 32'd45000;
	localparam logic [31:0] RST_CLOSE_LOCKOUT = 32'd10000;
	localparam logic [9:0]  RST_EXIT_BRAKE    = 10'd200;
	localparam logic [8:0]  RST_EXIT_STEER    = 9'd15;
	localparam logic [7:0]  RST_AUTO_SPEED    = 8'd5;
	localparam logic [9:0]  RST_AUTO_THROTTLE = 10'd750;
	localparam logic [9:0]  RST_AUTO_BRAKE    = 10'd100;
	localparam logic [8:0]  RST_AUTO_STEER    = 9'd15;

	typedef struct packed {
		logic [31:0] open_lockout_us;
		logic [31:0] close_lockout_us;
		logic [9:0]  exit_brake_permille;
		logic [8:0]  exit_steer_deg;
		logic [7:0]  auto_min_speed_mph;
		logic [9:0]  auto_min_throttle_permille;
		logic [9:0]  auto_max_brake_permille;
		logic [8:0]  auto_max_steer_deg;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        mode_select;
		logic              button_pressed;
		logic signed [9:0] steer_angle_deg;
		logic [9:0]        brake_permille;
		logic [9:0]        throttle_permille;
		logic [7:0]        ground_speed_mph;
		logic [31:0]       now_us;
	} item_t;

	typedef struct packed {
		logic flap_open;
		logic open_line;
		logic close_line;
		logic auto_active;
	} res_t;

endpackage

>>> src/dfm_cfg_regs.sv
// Configuration register file for the drag flap mode controller.
// Depends on dfm_pkg for the register indexes, reset values and cfg_t.
module dfm_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dfm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dfm_pkg::cfg_t                   cfg
);
	import dfm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_lockout_us            <= RST_OPEN_LOCKOUT;
			cfg_q.close_lockout_us           <= RST_CLOSE_LOCKOUT;
			cfg_q.exit_brake_permille        <= RST_EXIT_BRAKE;
			cfg_q.exit_steer_deg             <= RST_EXIT_STEER;
			cfg_q.auto_min_speed_mph         <= RST_AUTO_SPEED;
			cfg_q.auto_min_throttle_permille <= RST_AUTO_THROTTLE;
			cfg_q.auto_max_brake_permille    <= RST_AUTO_BRAKE;
			cfg_q.auto_max_steer_deg         <= RST_AUTO_STEER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OPEN_LOCKOUT:  cfg_q.open_lockout_us            <= cfg_data;
				REG_CLOSE_LOCKOUT: cfg_q.close_lockout_us           <= cfg_data;
				REG_EXIT_BRAKE:    cfg_q.exit_brake_permille        <= cfg_data[9:0];
				REG_EXIT_STEER:    cfg_q.exit_steer_deg             <= cfg_data[8:0];
				REG_AUTO_SPEED:    cfg_q.auto_min_speed_mph         <= cfg_data[7:0];
				REG_AUTO_THROTTLE: cfg_q.auto_min_throttle_permille <= cfg_data[9:0];
				REG_AUTO_BRAKE:    cfg_q.auto_max_brake_permille    <= cfg_data[9:0];
				REG_AUTO_STEER:    cfg_q.auto_max_steer_deg         <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/dfm_decide.sv
// Flap state registers and the per-update mode decision logic.
// Depends on dfm_pkg for mode_t, cfg_t, item_t and res_t.
module dfm_decide (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  dfm_pkg::item_t item,
	input  dfm_pkg::cfg_t  cfg,
	output dfm_pkg::res_t  res
);
	import dfm_pkg::*;

	logic        flap_q;
	logic        lines_q;
	logic        auto_q;
	logic [31:0] mark_q;

	logic        flap_d;
	logic        lines_d;
	logic        auto_d;
	logic [31:0] mark_d;

	mode_t       mode;
	logic [31:0] elapsed;
	logic [9:0]  steer_mag;
	logic        open_ok;
	logic        close_ok;
	logic        flap_t;
	logic        exit_hit;
	logic        auto_ok;

	assign mode      = mode_t'(item.mode_select);
	assign elapsed   = item.now_us - mark_q;
	assign steer_mag = item.steer_angle_deg[9] ? (10'd0 - item.steer_angle_deg)
	                                           : item.steer_angle_deg;
	assign open_ok   = !flap_q && item.button_pressed && (elapsed >= cfg.open_lockout_us);
	assign close_ok  = flap_q && item.button_pressed && (elapsed >= cfg.close_lockout_us);
	assign flap_t    = open_ok ? 1'b1 : (close_ok ? 1'b0 : flap_q);
	assign exit_hit  = (item.brake_permille > cfg.exit_brake_permille)
	                || (steer_mag > {1'b0, cfg.exit_steer_deg});
	assign auto_ok   = (item.ground_speed_mph > cfg.auto_min_speed_mph)
	                && (item.throttle_permille > cfg.auto_min_throttle_permille)
	                && (steer_mag < {1'b0, cfg.auto_max_steer_deg})
	                && (item.brake_permille < cfg.auto_max_brake_permille);

	always_comb begin
		flap_d  = flap_q;
		lines_d = lines_q;
		auto_d  = auto_q;
		mark_d  = mark_q;
		unique case (mode)
			MODE_CLOSED: begin
				flap_d  = 1'b0;
				lines_d = 1'b1;
			end
			MODE_OPEN: begin
				flap_d  = 1'b1;
				lines_d = 1'b1;
			end
			MODE_HELD: begin
				flap_d  = item.button_pressed;
				lines_d = 1'b1;
			end
			MODE_TOGGLE: begin
				if (open_ok || close_ok) begin
					mark_d  = item.now_us;
					lines_d = 1'b1;
				end
				flap_d = flap_t;
				if (flap_t && exit_hit) begin
					flap_d  = 1'b0;
					lines_d = 1'b1;
				end
			end
			MODE_AUTO: begin
				auto_d = auto_ok;
				flap_d = auto_ok;
				if (auto_ok != flap_q) begin
					lines_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flap_q  <= 1'b0;
			lines_q <= 1'b0;
			auto_q  <= 1'b1;
			mark_q  <= 32'd0;
		end else if (step) begin
			flap_q  <= flap_d;
			lines_q <= lines_d;
			auto_q  <= auto_d;
			mark_q  <= mark_d;
		end
	end

	assign res.flap_open   = flap_d;
	assign res.open_line   = lines_d && flap_d;
	assign res.close_line  = lines_d && !flap_d;
	assign res.auto_active = auto_d;

	a_close_mode: assert property (@(posedge clk) disable iff (!arst_n)
		step && (item.mode_select == MODE_CLOSED) |=> !flap_q && lines_q)
		else $error("closed mode did not command the flap closed");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && (item.mode_select == 3'd5 || item.mode_select == 3'd6
		|| item.mode_select == 3'd7)
		|=> $stable(flap_q) && $stable(lines_q) && $stable(auto_q) && $stable(mark_q))
		else $error("idle mode changed the controller state");

	a_mark_toggle_only: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && item.mode_select == MODE_TOGGLE) |=> $stable(mark_q))
		else $error("toggle time mark moved outside toggle mode");

	a_lines_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lines_q |=> lines_q)
		else $error("drive lines dropped after being driven");

endmodule

>>> src/drag_flap_mode_controller.sv
// Top level of the drag flap mode controller: stream ports, input and result registers.
// Depends on dfm_pkg, dfm_cfg_regs and dfm_decide.
//
// Usage: each transfer on the s_ channel is one control update. s_tuser[2:0] carries the
// mode select and s_tdata the sensor fields and the microsecond time. Every update gives
// exactly one result transfer on the m_ channel with the commanded flap state, the two
// actuator drive levels and the auto status.
// An input transfer is captured in the input register; the decision logic then updates the
// flap state and loads the result register, which drives m_tvalid. Throughput is one update
// per cycle while m_tready is not held low; the flap state is rewritten in the same cycle
// that the decision is made, so consecutive updates follow with no gap.
// When the receiver holds m_tready low, the result register keeps its transfer, one more
// update waits in the input register, and s_tready then falls until the result is taken.
// Reset clears both pipeline stages, sets the flap closed with both drive lines low and the
// auto flag set, zeroes the toggle time mark and loads the default configuration.
// The cfg_ port writes a register when cfg_we is high; the user must use it only while no
// update is in flight, as the block itself does not enforce this.
module drag_flap_mode_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] button_pressed, [10:1] steer_angle_deg, [20:11] brake_permille,
	// [30:21] throttle_permille, [38:31] ground_speed_mph, [70:39] now_us, [71] zero
	input  logic [71:0]                     s_tdata,
	// [2:0] mode_select
	input  logic [2:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] flap_open, [1] open_line, [2] close_line, [3] auto_active, [7:4] zero
	output logic [7:0]                      m_tdata,
	input  logic                            cfg_we,
	input  logic [dfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dfm_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;
	logic  step;
	logic  take;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;
	assign take     = s_tvalid && s_tready;

	dfm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dfm_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.mode_select       <= s_tuser;
			item_s1.button_pressed    <= s_tdata[0];
			item_s1.steer_angle_deg   <= s_tdata[10:1];
			item_s1.brake_permille    <= s_tdata[20:11];
			item_s1.throttle_permille <= s_tdata[30:21];
			item_s1.ground_speed_mph  <= s_tdata[38:31];
			item_s1.now_us            <= s_tdata[70:39];
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.auto_active, res_s2.close_line,
	                   res_s2.open_line, res_s2.flap_open};

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |=> valid_s2 && $stable(res_s2))
		else $error("stalled result changed");

	a_lines_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.open_line && res_s2.close_line))
		else $error("both drive lines high");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("pending update lost during stall");

endmodule

>>> verif/drag_flap_mode_controller_tb.sv
// Self-checking testbench for drag_flap_mode_controller: drives control updates and checks
// every result transfer against a flap command predictor kept in a small scoreboard class.
// Depends on dfm_pkg and the controller RTL only.
module drag_flap_mode_controller_tb;
	import dfm_pkg::*;

	localparam logic [2:0] MODE_IDLE_A = 3'd5;
	localparam logic [2:0] MODE_IDLE_B = 3'd6;
	localparam logic [2:0] MODE_IDLE_C = 3'd7;
	localparam int NUM_REGS = 8;
	localparam int NUM_PHASES = 5;
	localparam int UPDATES_PER_PHASE = 240;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;

	class flap_command_checker;
		cfg_t cfg;
		logic flap;
		logic driven;
		logic auto_on;
		logic [31:0] mark;
		res_t pending_cmds[$];
		int errors;

		function new();
			cfg.open_lockout_us = RST_OPEN_LOCKOUT;
			cfg.close_lockout_us = RST_CLOSE_LOCKOUT;
			cfg.exit_brake_permille = RST_EXIT_BRAKE;
			cfg.exit_steer_deg = RST_EXIT_STEER;
			cfg.auto_min_speed_mph = RST_AUTO_SPEED;
			cfg.auto_min_throttle_permille = RST_AUTO_THROTTLE;
			cfg.auto_max_brake_permille = RST_AUTO_BRAKE;
			cfg.auto_max_steer_deg = RST_AUTO_STEER;
			flap = 1'b0;
			driven = 1'b0;
			auto_on = 1'b1;
			mark = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
			case (idx)
				REG_OPEN_LOCKOUT: cfg.open_lockout_us = v;
				REG_CLOSE_LOCKOUT: cfg.close_lockout_us = v;
				REG_EXIT_BRAKE: cfg.exit_brake_permille = v[9:0];
				REG_EXIT_STEER: cfg.exit_steer_deg = v[8:0];
				REG_AUTO_SPEED: cfg.auto_min_speed_mph = v[7:0];
				REG_AUTO_THROTTLE: cfg.auto_min_throttle_permille = v[9:0];
				REG_AUTO_BRAKE: cfg.auto_max_brake_permille = v[9:0];
				default: cfg.auto_max_steer_deg = v[8:0];
			endcase
		endfunction

		function void drive_flap(logic open_it);
			flap = open_it;
			driven = 1'b1;
		endfunction

		function void note_update(item_t it);
			logic [31:0] age;
			logic [9:0] steer_abs;
			res_t want;
			age = it.now_us - mark;
			steer_abs = it.steer_angle_deg[9] ? (~it.steer_angle_deg + 10'd1) : it.steer_angle_deg;
			case (it.mode_select)
				MODE_CLOSED: drive_flap(1'b0);
				MODE_OPEN: drive_flap(1'b1);
				MODE_HELD: drive_flap(it.button_pressed);
				MODE_TOGGLE: begin
					if (!flap && it.button_pressed && age >= cfg.open_lockout_us) begin
						mark = it.now_us;
						drive_flap(1'b1);
					end else if (flap && it.button_pressed && age >= cfg.close_lockout_us) begin
						mark = it.now_us;
						drive_flap(1'b0);
					end
					// The safety close acts on the state left by the toggle and keeps the mark.
					if (flap && (it.brake_permille > cfg.exit_brake_permille ||
							steer_abs > cfg.exit_steer_deg))
						drive_flap(1'b0);
				end
				MODE_AUTO: begin
					if (it.ground_speed_mph > cfg.auto_min_speed_mph &&
							it.throttle_permille > cfg.auto_min_throttle_permille &&
							steer_abs < cfg.auto_max_steer_deg &&
							it.brake_permille < cfg.auto_max_brake_permille) begin
						auto_on = 1'b1;
						if (!flap)
							drive_flap(1'b1);
					end else begin
						auto_on = 1'b0;
						if (flap)
							drive_flap(1'b0);
					end
				end
				default: ;
			endcase
			want.flap_open = flap;
			want.open_line = driven & flap;
			want.close_line = driven & ~flap;
			want.auto_active = auto_on;
			pending_cmds.push_back(want);
		endfunction

		function void check_result(logic [7:0] d);
			res_t want;
			logic [3:0] want_bits;
			string field_name[4];
			field_name = '{"flap_open", "open_line", "close_line", "auto_active"};
			if (pending_cmds.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transfer, expected none, actual %0h", $time, d);
				return;
			end
			want = pending_cmds.pop_front();
			want_bits = {want.auto_active, want.close_line, want.open_line, want.flap_open};
			for (int i = 0; i < 4; i++)
				if (d[i] !== want_bits[i]) begin
					errors++;
					$display("%0t: %s expected %0b actual %0b", $time, field_name[i],
						want_bits[i], d[i]);
				end
			if (d[7:4] !== 4'b0000) begin
				errors++;
				$display("%0t: padding expected 0 actual %0h", $time, d[7:4]);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [71:0] s_tdata;
	logic [2:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	flap_command_checker sb;
	int src_idle_pct;
	int sink_idle_pct;
	bit hold_req;
	logic [31:0] clock_us;
	logic [2:0] run_mode;
	int run_left;
	int quiet_cycles;

	drag_flap_mode_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int around(int centre, int spread);
		return centre + int'($urandom_range(2 * spread)) - spread;
	endfunction

	function automatic item_t update_of(logic [2:0] mode, logic btn, int steer, int brake,
			int throttle, int speed, logic [31:0] now);
		item_t it;
		it.mode_select = mode;
		it.button_pressed = btn;
		it.steer_angle_deg = 10'(steer);
		it.brake_permille = 10'(brake);
		it.throttle_permille = 10'(throttle);
		it.ground_speed_mph = 8'(speed);
		it.now_us = now;
		return it;
	endfunction

	function automatic item_t random_update();
		item_t it;
		int steer_edge;
		int brake_edge;
		if (run_left == 0) begin
			run_left = $urandom_range(1, 12);
			case ($urandom_range(9))
				0: run_mode = MODE_CLOSED;
				1: run_mode = MODE_OPEN;
				2: run_mode = MODE_HELD;
				3, 4, 5: run_mode = MODE_TOGGLE;
				6, 7, 8: run_mode = MODE_AUTO;
				default: run_mode = 3'($urandom_range(MODE_IDLE_A, MODE_IDLE_C));
			endcase
		end
		run_left--;
		it.mode_select = ($urandom_range(19) == 0) ? 3'($urandom) : run_mode;
		it.button_pressed = 1'($urandom_range(1));
		steer_edge = (run_mode == MODE_TOGGLE) ? int'(sb.cfg.exit_steer_deg) :
			int'(sb.cfg.auto_max_steer_deg);
		brake_edge = (run_mode == MODE_TOGGLE) ? int'(sb.cfg.exit_brake_permille) :
			int'(sb.cfg.auto_max_brake_permille);
		case ($urandom_range(2))
			0: it.steer_angle_deg = 10'(around(steer_edge, 2) * ($urandom_range(1) ? 1 : -1));
			1: it.steer_angle_deg = 10'(around(0, 20));
			default: it.steer_angle_deg = 10'($urandom);
		endcase
		case ($urandom_range(2))
			0: it.brake_permille = 10'(around(brake_edge, 2));
			1: it.brake_permille = 10'($urandom_range(150));
			default: it.brake_permille = 10'($urandom);
		endcase
		case ($urandom_range(2))
			0: it.throttle_permille = 10'(around(int'(sb.cfg.auto_min_throttle_permille), 2));
			1: it.throttle_permille = 10'($urandom_range(700, 1000));
			default: it.throttle_permille = 10'($urandom);
		endcase
		case ($urandom_range(2))
			0: it.ground_speed_mph = 8'(around(int'(sb.cfg.auto_min_speed_mph), 2));
			1: it.ground_speed_mph = 8'($urandom_range(20, 120));
			default: it.ground_speed_mph = 8'($urandom);
		endcase
		case ($urandom_range(15))
			0: clock_us = $urandom;
			1, 2, 3: clock_us = sb.mark + (sb.flap ? sb.cfg.close_lockout_us :
				sb.cfg.open_lockout_us) + 32'($urandom_range(2)) - 32'd1;
			default: clock_us = clock_us + 32'($urandom_range(30000));
		endcase
		it.now_us = clock_us;
		return it;
	endfunction

	function automatic logic [31:0] setting_for(int phase, logic [CFG_IDX_W-1:0] idx);
		logic [31:0] widest;
		logic [31:0] typical;
		case (idx)
			REG_OPEN_LOCKOUT, REG_CLOSE_LOCKOUT: begin
				widest = 32'hFFFF_FFFF;
				typical = $urandom_range(80000);
			end
			REG_EXIT_BRAKE, REG_AUTO_THROTTLE, REG_AUTO_BRAKE: begin
				widest = 32'h3FF;
				typical = $urandom_range(1000);
			end
			REG_EXIT_STEER, REG_AUTO_STEER: begin
				widest = 32'h1FF;
				typical = $urandom_range(60);
			end
			default: begin
				widest = 32'hFF;
				typical = $urandom_range(60);
			end
		endcase
		case (phase)
			1: return 32'h0;
			2: return widest;
			3: return $urandom;
			default: return typical;
		endcase
	endfunction

	task automatic send_update(input item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.mode_select;
		s_tdata <= {1'b0, it.now_us, it.ground_speed_mph, it.throttle_permille,
			it.brake_permille, it.steer_angle_deg, it.button_pressed};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_update(it);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		while (sb.pending_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Result side: random back-pressure plus one long hold requested by the stimulus.
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		item_t directed_q[$];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		clock_us = '0;
		run_left = 0;
		run_mode = MODE_TOGGLE;
		src_idle_pct = 13;
		sink_idle_pct = 45;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_q.push_back(update_of(MODE_IDLE_C, 1'b0, 0, 0, 0, 0, 32'h0));
		directed_q.push_back(update_of(MODE_IDLE_A, 1'b1, -512, 1023, 1023, 255, 32'hFFFF_FFFF));
		directed_q.push_back(update_of(MODE_AUTO, 1'b0, 14, 99, 751, 6, 32'd100));
		directed_q.push_back(update_of(MODE_AUTO, 1'b0, 14, 99, 751, 6, 32'd200));
		directed_q.push_back(update_of(MODE_AUTO, 1'b0, -15, 99, 751, 6, 32'd300));
		directed_q.push_back(update_of(MODE_AUTO, 1'b0, 0, 0, 1000, 5, 32'd400));
		directed_q.push_back(update_of(MODE_AUTO, 1'b0, -14, 99, 751, 6, 32'd500));
		directed_q.push_back(update_of(MODE_IDLE_B, 1'b0, 0, 0, 0, 0, 32'd0));
		directed_q.push_back(update_of(MODE_CLOSED, 1'b1, 511, 1000, 1000, 255, 32'hFFFF_FFFF));
		directed_q.push_back(update_of(MODE_OPEN, 1'b0, 0, 0, 0, 0, 32'd0));
		directed_q.push_back(update_of(MODE_HELD, 1'b0, 0, 0, 0, 0, 32'd0));
		directed_q.push_back(update_of(MODE_HELD, 1'b1, 0, 0, 0, 0, 32'd0));
		directed_q.push_back(update_of(MODE_CLOSED, 1'b0, 0, 0, 0, 0, 32'd0));
		// Lockout edges measured from the zero mark left by reset.
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b1, 0, 0, 0, 0, 32'd44999));
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b1, 0, 0, 0, 0, 32'd45000));
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b1, 0, 0, 0, 0, 32'd54999));
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b1, 0, 0, 0, 0, 32'd55000));
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b0, 0, 0, 0, 0, 32'd100000));
		// Opening and the safety close happen in the same update.
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b1, 0, 201, 0, 0, 32'd100000));
		directed_q.push_back(update_of(MODE_OPEN, 1'b0, 0, 0, 0, 0, 32'd0));
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b0, -16, 0, 0, 0, 32'd100001));
		directed_q.push_back(update_of(MODE_OPEN, 1'b0, 0, 0, 0, 0, 32'd0));
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b0, 15, 200, 0, 0, 32'd100002));
		// The elapsed time wraps across the top of the microsecond counter.
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b1, 0, 0, 0, 0, 32'hFFFF_FF00));
		directed_q.push_back(update_of(MODE_TOGGLE, 1'b1, 0, 0, 0, 0, 32'hFFFF_FF00 + 32'd45000));
		foreach (directed_q[i])
			send_update(directed_q[i]);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				s_tvalid <= 1'b0;
				wait_for_results();
				for (int r = 0; r < NUM_REGS; r++)
					write_reg(r[CFG_IDX_W-1:0], setting_for(phase, r[CFG_IDX_W-1:0]));
				cfg_we <= 1'b0;
				src_idle_pct = (phase == 1) ? 45 : 0;
				sink_idle_pct = (phase == 1) ? 13 : 0;
			end
			for (int n = 0; n < UPDATES_PER_PHASE; n++) begin
				if (phase == 0 && n == UPDATES_PER_PHASE / 2)
					hold_req = 1'b1;
				send_update(random_update());
			end
		end
		s_tvalid <= 1'b0;
		wait_for_results();

		if (sb.errors == 0 && sb.pending_cmds.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
